### hw/rtl/dfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dfir_pkg;

  // Request modes
  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam int COEF_BITS      = 16;
  localparam int FRAC_BITS      = 15;
  localparam int TAP_INDEX_BITS = 6;
  localparam int TAP_COUNT_BITS = 7;

  // Broadcast control for every cell of the tap chain
  typedef struct packed {
    logic                        shift;
    logic                        clear;
    logic                        load;
    logic signed [COEF_BITS-1:0] tap_value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/dfir_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dfir_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               mode;
  logic signed [SAMPLE_BITS-1:0]            sample_in;
  logic [dfir_pkg::TAP_INDEX_BITS-1:0]      tap_index;
  logic signed [dfir_pkg::COEF_BITS-1:0]    tap_value;

  modport source (output valid, mode, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, mode, sample_in, tap_index, tap_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/dfir_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dfir_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface
`default_nettype wire

### hw/rtl/direct_form_fir_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Direct-form FIR filter built as a row of MAX_TAPS tap cells. Each cell keeps one history
// sample and one Q1.15 coefficient, multiplies them into a product register and adds the
// product to the partial sum passed from its left neighbor, so the sum ripples down the row
// one cell per clock. A filter request shifts its sample into the row; its result appears on
// dout once the sum has left the last cell (round half up, >>15, saturate, clipped flag), and
// the next request is taken only once that result has been handed to the output register.
// Load-coefficient and clear-history requests are accepted without starting the chain and
// give no result; mode 3 is dropped. A waiting result on dout does not block acceptance of
// new requests, only the final hand-off of the next result.
// active_taps (cfg_we/cfg_data) selects the taps in use: 0 acts as 1, values above
// MAX_TAPS act as MAX_TAPS. Write it only while no request is in flight.
module direct_form_fir_filter_core #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dfir_pkg::TAP_COUNT_BITS-1:0] cfg_data,
  dfir_in_if.sink                                  din,
  dfir_out_if.source                               dout
);

  localparam int ACC_BITS = SAMPLE_BITS + dfir_pkg::COEF_BITS + $clog2(MAX_TAPS) + 2;
  localparam int CNT_BITS = $clog2(MAX_TAPS + 2);
  // cycle count after acceptance at which the last cell holds the full sum
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(MAX_TAPS + 1);

  logic [dfir_pkg::TAP_COUNT_BITS-1:0] active_taps;
  logic                                busy;
  logic [CNT_BITS-1:0]                 cnt;
  logic                                accept;
  logic                                done;
  dfir_pkg::cell_ctrl_t                ctrl;

  logic signed [SAMPLE_BITS-1:0] samp_chain [MAX_TAPS];
  logic signed [ACC_BITS-1:0]    sum_chain  [MAX_TAPS];

  logic signed [SAMPLE_BITS-1:0] y;
  logic                          clip;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= dfir_pkg::TAP_COUNT_BITS'(1);
    end else if (cfg_we) begin
      active_taps <= cfg_data;
    end
  end

  // Request side: one filter request in the chain at a time
  assign din.ready = !busy;
  assign accept    = din.valid && !busy;

  always_comb begin
    ctrl.shift     = accept && (din.mode == dfir_pkg::MODE_FILTER);
    ctrl.load      = accept && (din.mode == dfir_pkg::MODE_LOAD);
    ctrl.clear     = accept && (din.mode == dfir_pkg::MODE_CLEAR);
    ctrl.tap_value = din.tap_value;
  end

  // Tap chain
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    logic                          sel;
    logic                          tap_on;
    logic signed [SAMPLE_BITS-1:0] samp_prev;
    logic signed [ACC_BITS-1:0]    sum_prev;

    assign sel    = (32'(din.tap_index) == 32'(k));
    // tap 0 is always on; cells past MAX_TAPS do not exist
    assign tap_on = (k == 0) || (32'(k) < 32'(active_taps));

    if (k == 0) begin : g_head
      assign samp_prev = din.sample_in;
      assign sum_prev  = '0;
    end else begin : g_body
      assign samp_prev = samp_chain[k-1];
      assign sum_prev  = sum_chain[k-1];
    end

    dfir_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ACC_BITS   (ACC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sel      (sel),
      .tap_on   (tap_on),
      .samp_prev(samp_prev),
      .samp     (samp_chain[k]),
      .sum_prev (sum_prev),
      .sum      (sum_chain[k])
    );
  end

  dfir_sat #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_sat (
    .acc (sum_chain[MAX_TAPS-1]),
    .y   (y),
    .clip(clip)
  );

  // Sequencer: count until the sum reaches the end of the row, then hand off
  assign done = busy && (cnt == LAST) && (!dout.valid || dout.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.shift) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && (cnt != LAST)) begin
      cnt <= cnt + CNT_BITS'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (done) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      dout.sample_out <= y;
      dout.clipped    <= clip;
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= LAST)
    else $error("sequence count past end of tap chain");

  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready && (din.mode == dfir_pkg::MODE_FILTER) |=> busy && (cnt == '0))
    else $error("filter request did not start the chain");

  a_other_idle: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready && (din.mode != dfir_pkg::MODE_FILTER) |=> !busy)
    else $error("load or clear request started the chain");

  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(busy) && ($past(cnt) == LAST))
    else $error("result issued before sum settled");

endmodule
`default_nettype wire

### hw/rtl/dfir_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dfir_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dfir_pkg::cell_ctrl_t          ctrl,
  input  wire logic                          sel,
  input  wire logic                          tap_on,
  input  wire logic signed [SAMPLE_BITS-1:0] samp_prev,
  output logic signed [SAMPLE_BITS-1:0]      samp,
  input  wire logic signed [ACC_BITS-1:0]    sum_prev,
  output logic signed [ACC_BITS-1:0]         sum
);

  localparam int PROD_BITS = SAMPLE_BITS + dfir_pkg::COEF_BITS;

  logic signed [dfir_pkg::COEF_BITS-1:0] coef;
  logic signed [PROD_BITS-1:0]           prod;

  // history tap
  always_ff @(posedge clk) begin
    if (rst) begin
      samp <= '0;
    end else if (ctrl.clear) begin
      samp <= '0;
    end else if (ctrl.shift) begin
      samp <= samp_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (ctrl.load && sel) begin
      coef <= ctrl.tap_value;
    end
  end

  // product, then partial sum handed to the next cell
  always_ff @(posedge clk) begin
    if (tap_on) begin
      prod <= PROD_BITS'(samp * coef);
    end else begin
      prod <= '0;
    end
    sum <= sum_prev + ACC_BITS'(prod);
  end

endmodule
`default_nettype wire

### hw/rtl/dfir_sat.sv
`timescale 1ns / 1ps
`default_nettype none
module dfir_sat #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 40
) (
  input  wire logic signed [ACC_BITS-1:0] acc,
  output logic signed [SAMPLE_BITS-1:0]   y,
  output logic                            clip
);

  localparam int SH_BITS = ACC_BITS + 1 - dfir_pkg::FRAC_BITS;
  localparam logic signed [ACC_BITS:0] RND =
    (ACC_BITS + 1)'(64'sd1 <<< (dfir_pkg::FRAC_BITS - 1));
  localparam logic signed [SH_BITS-1:0] HI =
    SH_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SH_BITS-1:0] LO =
    SH_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic signed [ACC_BITS:0]  rnd;
  logic signed [SH_BITS-1:0] shv;

  // round half up, floor shift, clamp
  always_comb begin
    rnd = (ACC_BITS + 1)'(acc) + RND;
    shv = SH_BITS'(rnd >>> dfir_pkg::FRAC_BITS);
    priority if (shv > HI) begin
      y    = SAMPLE_BITS'(HI);
      clip = 1'b1;
    end else if (shv < LO) begin
      y    = SAMPLE_BITS'(LO);
      clip = 1'b1;
    end else begin
      y    = SAMPLE_BITS'(shv);
      clip = 1'b0;
    end
  end

endmodule
`default_nettype wire

### dv/direct_form_fir_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the direct-form FIR core.
// Requests are driven on the falling edge. Handshakes and results are sampled on the rising
// edge. A scoreboard class keeps its own copy of the taps, the history and the tap count.
// It predicts every filtered sample and checks results in order.
module direct_form_fir_filter_core_tb;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;

  // mode 3 has no name in the package; the core must drop it silently
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // settle time: long enough for a filter request to pass through the tap chain, with margin
  localparam int SETTLE_CYCLES = MAX_TAPS + 8;
  // long receiver hold-off used to back the core up into its input
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_GUARD   = 20000;

  typedef struct packed {
    logic [1:0]                                mode;
    logic signed [SAMPLE_BITS-1:0]             sample;
    logic [dfir_pkg::TAP_INDEX_BITS-1:0]       tap_index;
    logic signed [dfir_pkg::COEF_BITS-1:0]     tap_value;
  } fir_request_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]   sample;
    logic                            clipped;
  } fir_output_t;

  // ------------------------------------------------------------------------------------
  // Scoreboard: mirrors coefficient store, sample history and tap count, predicts each
  // filtered sample and checks results as they arrive.
  // ------------------------------------------------------------------------------------
  class fir_scoreboard;
    logic signed [dfir_pkg::COEF_BITS-1:0] coef [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]         history [MAX_TAPS];
    int unsigned                           tap_count;
    fir_output_t                           filtered_q [$];
    int                                    errors;

    function new();
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef[k]    = '0;
        history[k] = '0;
      end
      tap_count = 1;
      errors    = 0;
    endfunction

    function void set_taps(input int unsigned value);
      tap_count = value;
    endfunction

    function int outstanding();
      return filtered_q.size();
    endfunction

    // One FIR step: shift the sample in, sum products, round half up, >>15, saturate.
    function fir_output_t filter_sample(input logic signed [SAMPLE_BITS-1:0] s);
      fir_output_t res;
      longint      acc;
      longint      y;
      int          n;
      int          k;
      n = (tap_count == 0) ? 1 : ((tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count));
      for (k = MAX_TAPS - 1; k > 0; k--)
        history[k] = history[k-1];
      history[0] = s;
      acc = 0;
      for (k = 0; k < n; k++)
        acc += longint'(coef[k]) * longint'(history[k]);
      y = (acc + (64'sd1 <<< (dfir_pkg::FRAC_BITS - 1))) >>> dfir_pkg::FRAC_BITS;
      res.clipped = 1'b0;
      if (y > 32767) begin
        y = 32767;
        res.clipped = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        res.clipped = 1'b1;
      end
      res.sample = y[SAMPLE_BITS-1:0];
      return res;
    endfunction

    function void accept_request(input fir_request_t r);
      case (r.mode)
        dfir_pkg::MODE_FILTER: filtered_q.push_back(filter_sample(r.sample));
        dfir_pkg::MODE_LOAD: coef[r.tap_index] = r.tap_value;
        dfir_pkg::MODE_CLEAR: begin
          for (int k = 0; k < MAX_TAPS; k++)
            history[k] = '0;
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_output(input logic signed [SAMPLE_BITS-1:0] s, input logic c);
      fir_output_t want;
      if (filtered_q.size() == 0) begin
        report($sformatf("unexpected result sample_out=%0d clipped=%0b", s, c));
      end else begin
        want = filtered_q.pop_front();
        if (s !== want.sample || c !== want.clipped)
          report($sformatf("sample_out=%0d clipped=%0b, expected %0d / %0b",
                           s, c, want.sample, want.clipped));
      end
    endtask
  endclass

  // ------------------------------------------------------------------------------------
  // Clock, reset, DUT
  // ------------------------------------------------------------------------------------
  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [dfir_pkg::TAP_COUNT_BITS-1:0] cfg_data;

  dfir_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) din_if ();
  dfir_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dout_if ();

  direct_form_fir_filter_core #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .din      (din_if),
    .dout     (dout_if)
  );

  fir_scoreboard sb = new();

  // lively: random idling allowed on both sides; hold_pending: ask for a long output hold
  bit lively       = 1'b1;
  bit hold_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------------------------
  // Result side: random backpressure bursts, plus the long hold-off when requested.
  // ------------------------------------------------------------------------------------
  initial begin : result_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        dout_if.ready <= 1'b0;
      end else if (lively && $urandom_range(0, 7) == 0) begin
        // start a stalled burst, this cycle included; stall_left counts the rest of it
        stall_left = $urandom_range(0, 14);
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready)
      sb.check_output(dout_if.sample_out, dout_if.clipped);
  end

  // ------------------------------------------------------------------------------------
  // Request side helpers
  // ------------------------------------------------------------------------------------

  // Present one request at the falling edge and hold it until the core takes it.
  task automatic send(input fir_request_t r);
    @(negedge clk);
    din_if.valid     <= 1'b1;
    din_if.mode      <= r.mode;
    din_if.sample_in <= r.sample;
    din_if.tap_index <= r.tap_index;
    din_if.tap_value <= r.tap_value;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    sb.accept_request(r);
  endtask

  task automatic idle_in(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      din_if.valid <= 1'b0;
    end
  endtask

  // Drop valid, wait for every prediction to be matched, then let the chain settle
  // (load/clear requests give no result but may still be in flight).
  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (sb.outstanding() != 0 && n < DRAIN_GUARD) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // active_taps write; only called with the core idle
  task automatic write_taps(input logic [dfir_pkg::TAP_COUNT_BITS-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_taps(value);
  endtask

  // Q1.15 value: extremes, full range, or scaled down so sums do not always saturate
  function automatic logic signed [15:0] pick_q15();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2, 3: ;
      4: v = v >>> 14;  // -2..1
      default: v = v >>> $urandom_range(3, 9);
    endcase
    return v;
  endfunction

  function automatic fir_request_t filter_req(input logic signed [15:0] s);
    fir_request_t r;
    r.mode      = dfir_pkg::MODE_FILTER;
    r.sample    = s;
    r.tap_index = 6'($urandom);
    r.tap_value = 16'($urandom);
    return r;
  endfunction

  function automatic fir_request_t load_req(input logic [5:0] idx,
                                             input logic signed [15:0] value);
    fir_request_t r;
    r.mode      = dfir_pkg::MODE_LOAD;
    r.sample    = 16'($urandom);
    r.tap_index = idx;
    r.tap_value = value;
    return r;
  endfunction

  function automatic fir_request_t other_req(input logic [1:0] mode);
    fir_request_t r;
    r.mode      = mode;
    r.sample    = 16'($urandom);
    r.tap_index = 6'($urandom);
    r.tap_value = 16'($urandom);
    return r;
  endfunction

  // Mostly filter traffic with random loads, occasional clears and dropped mode-3 requests.
  function automatic fir_request_t random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return filter_req(pick_q15());
    else if (pick < 88)
      return load_req(6'($urandom), pick_q15());
    else if (pick < 94)
      return other_req(dfir_pkg::MODE_CLEAR);
    else
      return other_req(MODE_UNUSED);
  endfunction

  task automatic run_random(input int count);
    repeat (count) begin
      if (lively && $urandom_range(0, 5) == 0)
        idle_in($urandom_range(1, 15));
      send(random_req());
    end
  endtask

  // ------------------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------------------
  initial begin : stimulus
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    din_if.valid     = 1'b0;
    din_if.mode      = dfir_pkg::MODE_FILTER;
    din_if.sample_in = '0;
    din_if.tap_index = '0;
    din_if.tap_value = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, tap count at its reset value (1) ---
    send(filter_req(16'sh7FFF));             // coefficients still zero after reset
    send(load_req(6'd0, 16'sh4000));         // coef0 = 0.5
    send(filter_req(16'sd1));                // exact +half rounds up to 1
    send(filter_req(-16'sd1));               // exact -half rounds up to 0
    send(other_req(MODE_UNUSED));            // dropped, no result
    send(filter_req(16'sh8000));
    send(load_req(6'd0, 16'sh8000));         // coef0 = -1.0
    send(filter_req(16'sh8000));             // (-1)*(-1) saturates high with one tap
    send(filter_req(16'sh7FFF));
    drain();

    // --- tap count 0 behaves as one tap ---
    write_taps(7'd0);
    send(load_req(6'd1, 16'sh8000));
    send(load_req(6'd63, 16'sh7FFF));        // highest index, unused with one tap
    send(filter_req(16'sh8000));
    send(filter_req(16'sd5));
    drain();

    // --- tap count above the maximum behaves as MAX_TAPS ---
    write_taps(7'd127);
    send(filter_req(16'sh8000));
    send(filter_req(16'sh8000));             // two -1*-1 products: clip high
    send(filter_req(16'sh7FFF));
    send(filter_req(16'sh7FFF));             // clip low
    send(other_req(dfir_pkg::MODE_CLEAR));   // history only; coefficients stay
    send(filter_req(16'sd100));
    drain();

    // --- random part ---
    write_taps(7'd64);
    for (int k = 0; k < MAX_TAPS; k++)
      send(load_req(6'(k), pick_q15()));

    // back the core up: output held off while filter requests keep coming
    lively       = 1'b0;
    hold_pending = 1'b1;
    repeat (12) send(filter_req(pick_q15()));
    lively = 1'b1;
    run_random(120);
    drain();

    write_taps(7'd1);
    run_random(100);
    drain();

    write_taps(7'($urandom_range(2, 63)));
    run_random(120);
    drain();

    // stretch without idling, out-of-range tap count
    lively = 1'b0;
    write_taps(7'($urandom_range(65, 126)));
    run_random(90);
    drain();

    lively = 1'b1;
    write_taps(7'd0);
    run_random(80);
    drain();

    write_taps(7'($urandom_range(1, 64)));
    run_random(90);
    drain();

    // final stretch: no idling on either side
    lively = 1'b0;
    write_taps(7'($urandom_range(2, 64)));
    run_random(70);
    drain();

    while (sb.outstanding() != 0)
      sb.report($sformatf("result never arrived, expected %0d",
                          sb.filtered_q.pop_front().sample));

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
